/* rtl/tlpi_pkg.sv */
// ----------------------------------------------------------------------------
// tlpi_pkg
// Shared constants and types for the two-lane LED pulse interleaver.
// ----------------------------------------------------------------------------
package tlpi_pkg;

  localparam int SLOTS_PER_BIT = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int WORDS_PER_RUN = SLOTS_PER_BIT * BITS_PER_BYTE;
  localparam int POS_W         = $clog2(WORDS_PER_RUN);
  localparam int SLOT_W        = $clog2(SLOTS_PER_BIT);
  localparam int CNT_W         = 4;
  localparam int IDX_W         = 2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS_PER_RUN - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(SLOTS_PER_BIT);

  localparam logic [15:0] ODD_LANE_MASK  = 16'hAAAA;
  localparam logic [15:0] EVEN_LANE_MASK = 16'h5555;

  localparam logic [CNT_W-1:0] ZERO_CNT_RESET = 4'd2;
  localparam logic [CNT_W-1:0] ONE_CNT_RESET  = 4'd6;

  localparam logic [IDX_W-1:0] REG_HIGH_SLOTS_ZERO = 2'd0;
  localparam logic [IDX_W-1:0] REG_HIGH_SLOTS_ONE  = 2'd1;

  typedef struct packed {
    logic [CNT_W-1:0] high_slots_for_zero;
    logic [CNT_W-1:0] high_slots_for_one;
  } pulse_cfg_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
    clamp_count = (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

endpackage

/* rtl/two_lane_led_pulse_interleaver.sv */
// ----------------------------------------------------------------------------
// two_lane_led_pulse_interleaver
// Expands a byte pair into 64 interleaved pulse words, one per slot.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_*       in   tdata: lane0_byte [7:0], lane1_byte [15:8]
// m_*       out  tdata: pulse_word [15:0]; tlast: last_word
// cfg_*     in   index 0 high_slots_for_zero, index 1 high_slots_for_one
//
// each request yields 64 words, one per cycle while m_tready is high,
// set by the 6-bit slot counter; the next request is taken in the cycle the
// last word loads, so requests run back to back.
// rst clears the counter, output valid and sets the counts to 2 and 6.
// a low m_tready while m_tvalid is high stalls the counter and the output register together.
// ----------------------------------------------------------------------------
module two_lane_led_pulse_interleaver
  import tlpi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // lane0_byte, lane1_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // pulse_word
  output logic             m_tlast,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  pulse_cfg_t       cfg;
  logic             busy;
  logic [POS_W-1:0] slot_position;
  logic [15:0]      held_lane_bytes;
  logic             advance;
  logic             emit;
  logic             run_end;
  logic             in_accept;
  logic [15:0]      word_next;

  assign advance   = !m_tvalid || m_tready;
  assign emit      = busy && advance;
  assign run_end   = emit && (slot_position == LAST_POS);
  assign s_tready  = !busy || run_end;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_slots_for_zero <= ZERO_CNT_RESET;
      cfg.high_slots_for_one  <= ONE_CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_SLOTS_ZERO: cfg.high_slots_for_zero <= cfg_data;
        REG_HIGH_SLOTS_ONE:  cfg.high_slots_for_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      slot_position <= '0;
    end else begin
      if (in_accept) begin
        busy          <= 1'b1;
        slot_position <= '0;
      end else if (run_end) begin
        busy          <= 1'b0;
        slot_position <= '0;
      end else if (emit) begin
        slot_position <= slot_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      held_lane_bytes <= {s_tdata[7:0], s_tdata[15:8]};
    end
  end

  tlpi_slot_encoder u_encoder (
    .lane0_byte    (held_lane_bytes[15:8]),
    .lane1_byte    (held_lane_bytes[7:0]),
    .slot_position (slot_position),
    .cfg           (cfg),
    .pulse_word    (word_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= word_next;
      m_tlast <= (slot_position == LAST_POS);
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> busy && (slot_position == '0))
    else $error("accepted request did not start a run at slot zero");

  a_pos_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    (slot_position != '0) |-> busy)
    else $error("slot counter moved while idle");

  a_run_end_marks_last: assert property (@(posedge clk) disable iff (rst)
    run_end |=> m_tvalid && m_tlast)
    else $error("final slot word not marked last");

  a_lane_masks_whole: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (((m_tdata & ODD_LANE_MASK) == 16'h0000)
               || ((m_tdata & ODD_LANE_MASK) == ODD_LANE_MASK))
              && (((m_tdata & EVEN_LANE_MASK) == 16'h0000)
               || ((m_tdata & EVEN_LANE_MASK) == EVEN_LANE_MASK)))
    else $error("pulse word lane bits not uniform");
`endif

endmodule

/* rtl/tlpi_slot_encoder.sv */
// ----------------------------------------------------------------------------
// tlpi_slot_encoder
// Builds the interleaved pulse word for one slot of a run from both lane bytes.
// ----------------------------------------------------------------------------
module tlpi_slot_encoder
  import tlpi_pkg::*;
(
  input  logic [7:0]       lane0_byte,
  input  logic [7:0]       lane1_byte,
  input  logic [POS_W-1:0] slot_position,
  input  pulse_cfg_t       cfg,
  output logic [15:0]      pulse_word
);

  logic [2:0]       bit_index;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0] zero_cnt;
  logic [CNT_W-1:0] one_cnt;
  logic [CNT_W-1:0] lane0_cnt;
  logic [CNT_W-1:0] lane1_cnt;
  logic             lane0_high;
  logic             lane1_high;

  always_comb begin
    bit_index  = 3'd7 - slot_position[POS_W-1:SLOT_W];
    slot       = slot_position[SLOT_W-1:0];
    zero_cnt   = clamp_count(cfg.high_slots_for_zero);
    one_cnt    = clamp_count(cfg.high_slots_for_one);
    lane0_cnt  = lane0_byte[bit_index] ? one_cnt : zero_cnt;
    lane1_cnt  = lane1_byte[bit_index] ? one_cnt : zero_cnt;
    lane0_high = CNT_W'(slot) < lane0_cnt;
    lane1_high = CNT_W'(slot) < lane1_cnt;
    pulse_word = (lane0_high ? ODD_LANE_MASK : 16'h0000)
               | (lane1_high ? EVEN_LANE_MASK : 16'h0000);
  end

endmodule
